// ----- hw/rtl/mlpq_pkg.sv -----
`default_nettype none
package mlpq_pkg;

    localparam int LEVELS          = 16;
    localparam int PER_LEVEL_DEPTH = 16;

    localparam int LVL_W    = $clog2(LEVELS);
    localparam int IDX_W    = $clog2(PER_LEVEL_DEPTH);
    localparam int CNT_W    = $clog2(PER_LEVEL_DEPTH + 1);
    localparam int MEM_DEPTH = LEVELS * PER_LEVEL_DEPTH;
    localparam int ADDR_W   = $clog2(MEM_DEPTH);

    localparam int OP_W      = 2;
    localparam int PRI_W     = 4;
    localparam int HANDLE_W  = 16;

    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

    // per-operation control from the level bookkeeping to the datapath
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
        logic              found;
        logic [PRI_W-1:0]  level;
        logic              is_empty;
        logic              dropped;
    } ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/multilevel_priority_fifo_queue.sv -----
// Pipeline: the level bookkeeping and the entry RAM read are registered into stage 1
// at the accepting edge; the beat then moves on to the output register, which drives
// m_tvalid, once that register is free or draining.
// Throughput: one beat per cycle while the result side keeps up; each beat does one
// RAM read, plus a write for an accepted enqueue, and one per-level head/tail/count update. The input stalls only when
// stage 1 and the output register both hold a beat and m_tready is low.
// Reset: synchronous, active low; clears all level counts, positions and valids.
// The entry RAM is not cleared; only held entries ever reach m_tdata.
`default_nettype none
module multilevel_priority_fifo_queue
    import mlpq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, low bit up: operation[1:0], priority_req[5:2], handle[21:6], zero pad
    input  wire logic [23:0] s_tdata,
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata, low bit up: found[0], out_handle[16:1], out_level[20:17],
    // is_empty[21], dropped[22], zero pad
    output logic [23:0]      m_tdata
);

    logic [OP_W-1:0]     s_op;
    logic [PRI_W-1:0]    s_pri;
    logic [HANDLE_W-1:0] s_handle;
    logic                accept;
    ctl_t                ctl;

    // entry RAM, one write and one registered read per cycle
    logic [HANDLE_W-1:0] mem [MEM_DEPTH];
    logic [HANDLE_W-1:0] rd_data_reg;

    // stage 1 holds the beat while the RAM read lands
    logic                st_valid_reg;
    logic                st_found_reg;
    logic [PRI_W-1:0]    st_level_reg;
    logic                st_empty_reg;
    logic                st_drop_reg;
    logic                st_move;

    // output register
    logic                m_valid_reg;
    logic                m_found_reg;
    logic [HANDLE_W-1:0] m_handle_reg;
    logic [PRI_W-1:0]    m_level_reg;
    logic                m_empty_reg;
    logic                m_drop_reg;

    assign s_op     = s_tdata[1:0];
    assign s_pri    = s_tdata[5:2];
    assign s_handle = s_tdata[21:6];

    // stage 1 can hand off whenever the output slot is free or draining,
    // so a new beat comes in even while a result sits in the output register
    assign st_move  = st_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || st_move;
    assign accept   = s_tvalid && s_tready;

    mlpq_lvl_ctrl u_lvl_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .op      (s_op),
        .pri     (s_pri),
        .ctl     (ctl)
    );

    // a beat's write and read share an edge, but an enqueue never uses its read
    // data; a read by a later beat sees the written data, so no bypass is needed
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= s_handle;
        end
        if (accept) begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (accept) begin
            st_valid_reg <= 1'b1;
        end else if (st_move) begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_found_reg <= ctl.found;
            st_level_reg <= ctl.level;
            st_empty_reg <= ctl.is_empty;
            st_drop_reg  <= ctl.dropped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_move) begin
            m_found_reg  <= st_found_reg;
            m_handle_reg <= st_found_reg ? rd_data_reg : '0;
            m_level_reg  <= st_level_reg;
            m_empty_reg  <= st_empty_reg;
            m_drop_reg   <= st_drop_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_drop_reg, m_empty_reg, m_level_reg, m_handle_reg, m_found_reg};

`ifndef SYNTHESIS
    // an operation never both returns an entry and drops one
    a_found_xor_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_found_reg && m_drop_reg))
        else $error("result both found and dropped");

    // a miss carries zero handle and level
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_handle_reg == '0) && (m_level_reg == '0))
        else $error("miss with nonzero handle or level");

    // both stages full and the output stalled: no new beat may enter
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("beat accepted while pipeline stalled");

    // a beat in stage 1 moves into an empty output register at the next edge
    a_stage_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg && !m_valid_reg) |=> m_valid_reg)
        else $error("stage 1 beat did not advance");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/mlpq_lvl_ctrl.sv -----
`default_nettype none
module mlpq_lvl_ctrl
    import mlpq_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [OP_W-1:0]  op,
    input  wire logic [PRI_W-1:0] pri,
    output ctl_t                  ctl
);

    logic [IDX_W-1:0] head_reg [LEVELS];
    logic [IDX_W-1:0] head_next [LEVELS];
    logic [IDX_W-1:0] tail_reg [LEVELS];
    logic [IDX_W-1:0] tail_next [LEVELS];
    logic [CNT_W-1:0] cnt_reg [LEVELS];
    logic [CNT_W-1:0] cnt_next [LEVELS];

    logic [LEVELS-1:0] nonempty;
    logic [LEVELS-1:0] nonempty_next;
    logic [LEVELS-1:0] full;
    logic [LVL_W-1:0]  pri_idx;
    logic              pri_ok;
    logic [LVL_W-1:0]  lv;
    logic              any;
    logic              enq_ok;
    logic              deq_ok;
    logic [IDX_W-1:0]  hd;
    logic [IDX_W-1:0]  tl;

    function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
        next_pos = (p == IDX_W'(PER_LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            nonempty[i] = (cnt_reg[i] != '0);
            full[i]     = (cnt_reg[i] == CNT_W'(PER_LEVEL_DEPTH));
        end
    end

    // priority encoder, lowest level wins
    always_comb begin
        lv = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (nonempty[i]) begin
                lv = LVL_W'(i);
            end
        end
        any = |nonempty;
    end

    assign pri_ok  = (32'(pri) < LEVELS);
    assign pri_idx = LVL_W'(pri);
    assign hd      = head_reg[lv];
    assign tl      = tail_reg[pri_idx];
    assign enq_ok  = (op == OP_ENQ) && pri_ok && !full[pri_idx];
    assign deq_ok  = (op == OP_DEQ) && any;

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            cnt_next[i]  = cnt_reg[i];
            if (step && enq_ok && (pri_idx == LVL_W'(i))) begin
                tail_next[i] = next_pos(tail_reg[i]);
                cnt_next[i]  = cnt_next[i] + 1'b1;
            end
            if (step && deq_ok && (lv == LVL_W'(i))) begin
                head_next[i] = next_pos(head_reg[i]);
                cnt_next[i]  = cnt_next[i] - 1'b1;
            end
            nonempty_next[i] = (cnt_next[i] != '0);
        end
    end

    always_comb begin
        ctl.wr_en    = step && enq_ok;
        ctl.wr_addr  = ADDR_W'(int'(pri_idx) * PER_LEVEL_DEPTH + int'(tl));
        ctl.rd_addr  = ADDR_W'(int'(lv) * PER_LEVEL_DEPTH + int'(hd));
        ctl.found    = ((op == OP_DEQ) || (op == OP_PEEK)) && any;
        ctl.level    = ctl.found ? PRI_W'(lv) : '0;
        ctl.is_empty = (nonempty_next == '0);
        ctl.dropped  = (op == OP_ENQ) && !enq_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- tb/sv/tb_multilevel_priority_fifo_queue.sv -----
`default_nettype none
module tb_multilevel_priority_fifo_queue
    import mlpq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no beat on either side before the run is declared hung.
    // Worst legit gap is the receiver hold-off below plus a few random stalls.
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES  = 300;
    // Idle time after the last result; leave margin for stray beats.
    localparam int unsigned DRAIN_CYCLES = 16;

    // One result beat, laid out as on m_tdata (found in bit 0).
    typedef struct packed {
        logic                dropped;
        logic                is_empty;
        logic [PRI_W-1:0]    out_level;
        logic [HANDLE_W-1:0] out_handle;
        logic                found;
    } reply_t;

    // Scoreboard: shadow copy of the per-level FIFOs plus the replies in flight.
    class queue_reply_checker;
        logic [HANDLE_W-1:0] level_mem [LEVELS][PER_LEVEL_DEPTH];
        logic [IDX_W-1:0]    rd_pos    [LEVELS];
        logic [IDX_W-1:0]    wr_pos    [LEVELS];
        logic [CNT_W-1:0]    held      [LEVELS];
        reply_t              pending_replies[$];
        int unsigned         errors;
        int unsigned         n_enq, n_drop, n_deq, n_peek, n_miss, n_nop;

        function new();
            foreach (held[i]) begin
                rd_pos[i] = '0;
                wr_pos[i] = '0;
                held[i]   = '0;
            end
            errors = 0;
            n_enq = 0; n_drop = 0; n_deq = 0; n_peek = 0; n_miss = 0; n_nop = 0;
        endfunction

        // lowest level holding an entry, LEVELS when all are empty
        function int top_level();
            for (int lv = 0; lv < LEVELS; lv++)
                if (held[lv] != 0) return lv;
            return LEVELS;
        endfunction

        function logic [IDX_W-1:0] bump(logic [IDX_W-1:0] p);
            return (p == IDX_W'(PER_LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        // Apply one accepted request to the shadow state and queue its reply.
        function void note_request(logic [OP_W-1:0] op, logic [PRI_W-1:0] pri,
                                   logic [HANDLE_W-1:0] h);
            reply_t r;
            int     lv;
            r  = '0;
            lv = top_level();
            case (op)
                OP_ENQ: begin
                    n_enq++;
                    if (int'(pri) >= LEVELS || held[pri] >= PER_LEVEL_DEPTH) begin
                        r.dropped = 1'b1;
                        n_drop++;
                    end else begin
                        level_mem[pri][wr_pos[pri]] = h;
                        wr_pos[pri] = bump(wr_pos[pri]);
                        held[pri]++;
                    end
                end
                OP_DEQ, OP_PEEK: begin
                    if (op == OP_DEQ) n_deq++;
                    else n_peek++;
                    if (lv < LEVELS) begin
                        r.found      = 1'b1;
                        r.out_handle = level_mem[lv][rd_pos[lv]];
                        r.out_level  = PRI_W'(lv);
                        if (op == OP_DEQ) begin
                            rd_pos[lv] = bump(rd_pos[lv]);
                            held[lv]--;
                        end
                    end else begin
                        n_miss++;
                    end
                end
                default: n_nop++;
            endcase
            r.is_empty = (top_level() == LEVELS);
            pending_replies.push_back(r);
        endfunction

        task check_reply(logic [23:0] d);
            reply_t got, exp_r;
            got = d[22:0];
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("result beat %h with nothing pending", d));
                return;
            end
            exp_r = pending_replies.pop_front();
            if (got.found !== exp_r.found)
                report_mismatch($sformatf("found %b, want %b", got.found, exp_r.found));
            if (got.out_handle !== exp_r.out_handle)
                report_mismatch($sformatf("out_handle %h, want %h",
                                          got.out_handle, exp_r.out_handle));
            if (got.out_level !== exp_r.out_level)
                report_mismatch($sformatf("out_level %0d, want %0d",
                                          got.out_level, exp_r.out_level));
            if (got.is_empty !== exp_r.is_empty)
                report_mismatch($sformatf("is_empty %b, want %b",
                                          got.is_empty, exp_r.is_empty));
            if (got.dropped !== exp_r.dropped)
                report_mismatch($sformatf("dropped %b, want %b",
                                          got.dropped, exp_r.dropped));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // s_tdata, low bit up: operation[1:0], priority_req[5:2], handle[21:6], zero pad
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // m_tdata, low bit up: found[0], out_handle[16:1], out_level[20:17],
    // is_empty[21], dropped[22], zero pad
    logic [23:0] m_tdata;

    queue_reply_checker sb;

    int unsigned tx_idle_pct;   // chance per cycle that the sender holds back
    int unsigned rx_idle_pct;   // chance per cycle that m_tready is low
    logic        hold_req;      // asks the receiver for one long hold-off
    int unsigned quiet_cycles;

    multilevel_priority_fifo_queue DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    // Sender: random idle cycles in front of each beat, then hold it until taken.
    // tvalid is only dropped when an idle cycle follows, so back-to-back beats
    // never see a low/high pair in one step.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [PRI_W-1:0] pri,
                             input logic [HANDLE_W-1:0] h);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, h, pri, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, pri, h);
    endtask

    // Directed: empty-queue misses, no-op, both ends of level and handle range,
    // strict priority ordering, one level filled to the brim plus a dropped beat.
    task automatic directed_traffic();
        send_beat(OP_DEQ,  4'd0,  16'h0000);  // dequeue on empty queue
        send_beat(OP_PEEK, 4'd9,  16'hFFFF);  // peek on empty queue
        send_beat(OP_NOP,  4'd0,  16'h0000);  // no-op while empty
        send_beat(OP_ENQ,  4'd15, 16'hFFFF);  // lowest priority level
        send_beat(OP_ENQ,  4'd0,  16'h0000);  // highest priority level
        send_beat(OP_PEEK, 4'd15, 16'hFFFF);  // must see level 0
        send_beat(OP_NOP,  4'd15, 16'hFFFF);  // no-op while not empty
        send_beat(OP_DEQ,  4'd0,  16'h0000);
        send_beat(OP_DEQ,  4'd0,  16'h0000);  // level 15 now
        send_beat(OP_DEQ,  4'd0,  16'h0000);  // dequeue on empty queue again
        for (int i = 0; i < PER_LEVEL_DEPTH; i++)
            send_beat(OP_ENQ, 4'd7, 16'hA500 | 16'(i));
        send_beat(OP_ENQ,  4'd7,  16'h1234);  // full level, dropped
    endtask

    // Random traffic in segments that lean toward filling, draining or a mix,
    // with enqueues bunched on a couple of hot levels so levels fill and wrap.
    task automatic random_traffic(input int unsigned count);
        int unsigned     left, seg_len, style, hot, roll;
        int unsigned     w_enq, w_deq, w_peek;
        logic [OP_W-1:0] op;
        logic [PRI_W-1:0] pri;
        logic [HANDLE_W-1:0] h;
        left = count;
        while (left > 0) begin
            seg_len = $urandom_range(80, 20);
            if (seg_len > left) seg_len = left;
            style = $urandom_range(2);
            hot   = $urandom_range(LEVELS - 2);
            case (style)
                0:       begin w_enq = 75; w_deq = 10; w_peek = 10; end  // fill
                1:       begin w_enq = 15; w_deq = 70; w_peek = 10; end  // drain
                default: begin w_enq = 45; w_deq = 35; w_peek = 12; end
            endcase
            repeat (seg_len) begin
                roll = $urandom_range(99);
                if (roll < w_enq)                        op = OP_ENQ;
                else if (roll < w_enq + w_deq)           op = OP_DEQ;
                else if (roll < w_enq + w_deq + w_peek)  op = OP_PEEK;
                else                                     op = OP_NOP;
                if ($urandom_range(99) < 60) pri = PRI_W'(hot + $urandom_range(1));
                else                         pri = PRI_W'($urandom_range(LEVELS - 1));
                roll = $urandom_range(99);
                if (roll < 8)       h = '0;
                else if (roll < 16) h = '1;
                else                h = HANDLE_W'($urandom);
                send_beat(op, pri, h);
            end
            left -= seg_len;
        end
    endtask

    // Receiver: checks every accepted result beat, drives m_tready at random,
    // and on request holds m_tready low for a long counted stretch.
    initial begin
        int unsigned hold_left;
        logic        hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_reply(m_tdata);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: any beat on either side resets the count.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, sb.pending_replies.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        sb           = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        hold_req     = 1'b0;
        tx_idle_pct  = 37;
        rx_idle_pct  = 79;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // phase 1: sender idles 37%, receiver 79%
        directed_traffic();
        random_traffic(450);

        // phase 2: swapped
        tx_idle_pct = 79;
        rx_idle_pct = 37;
        random_traffic(450);

        // phase 3: no idling; long receiver hold-off first so the input backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req <= 1'b1;
        random_traffic(500);
        s_tvalid <= 1'b0;

        while (sb.pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d enqueues (%0d dropped on full levels), %0d dequeues, %0d peeks",
                 sb.n_enq, sb.n_drop, sb.n_deq, sb.n_peek);
        $display("%0d dequeue/peek on empty queue, %0d no-ops, %0d field errors",
                 sb.n_miss, sb.n_nop, sb.errors);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire
